FILE: rtl/tcv_pkg.sv
// Shared widths, constants and bundle types for the tetrahedron six-volume
// and refinement-site pipeline. No dependencies.
package tcv_pkg;

	// Coordinate and fixed-point format
	localparam int COORD_BITS = 16;
	localparam int FRAC_BITS  = 8;
	localparam int NUM_CRD    = 12;
	localparam int IN_W       = NUM_CRD * COORD_BITS;

	// Derived arithmetic widths
	localparam int DW    = COORD_BITS + 1;        // edge vector component
	localparam int XW    = 2 * DW;                // cross product component
	localparam int NW    = 2 * DW;                // squared edge length
	localparam int VW    = 3 * DW + 1;            // signed six-volume
	localparam int AVW   = VW - 1;                // |V|
	localparam int NKW   = 4 * DW + 2;            // circumcenter numerator N
	localparam int ANW   = NKW - 1;               // |N|
	localparam int NUMW  = ANW + FRAC_BITS + 1;   // quotient dividend
	localparam int DENW  = AVW + 1;               // quotient divisor 2|V|
	localparam int QW    = 33;                    // quotient bits kept
	localparam int SITE_W = 32;
	localparam int SUMW  = COORD_BITS + 2;        // sum of four coordinates
	localparam int CENW  = SUMW + FRAC_BITS;
	localparam int AFW   = COORD_BITS + FRAC_BITS;
	localparam int SIXV_W = 51;
	localparam int RAD_W = 23;
	localparam int R2W   = 2 * RAD_W;
	localparam int V2W   = 2 * AVW;
	localparam int M2W   = 2 * NW;
	localparam int M3W   = 3 * NW;
	localparam int N2W   = 2 * ANW;
	localparam int NNW   = N2W + 2;

	// Sliver test: 4e24 = 5^24 * 2^26
	localparam int SLIV_KW = 56;
	localparam int SLIV_SH = 26;
	localparam logic [SLIV_KW-1:0] SLIV_K = 56'd59604644775390625;

	// Multiplier and divider pipelines
	localparam int MUL_CHUNK = 32;
	localparam int MUL_LAT   = 2;
	localparam int DIV_LAT   = QW + 1;

	// Stream and register port
	localparam int OUT_DW = 152;
	localparam int APB_AW = 4;
	localparam int APB_DW = 64;
	localparam logic [RAD_W-1:0] RAD_RESET = 23'h7FFFFF;

	typedef enum logic [0:0] {
		REG_MAX_VOL = 1'b0,
		REG_RAD_LIM = 1'b1
	} reg_idx_t;

	// Per-item data that rides alongside the divider
	typedef struct packed {
		logic [SIXV_W-1:0]         six_volume;
		logic                      over_bound;
		logic                      vnz;
		logic [2:0]                neg;
		logic [2:0][AFW-1:0]       a_fix;
		logic [2:0][SITE_W-1:0]    cent;
	} side_t;

	// Front-end result handed to the back end
	typedef struct packed {
		side_t                     side;
		logic [2:0][NUMW-1:0]      num;
		logic [DENW-1:0]           den;
		logic [AVW-1:0]            absv;
		logic [2:0][ANW-1:0]       absn;
		logic [NW-1:0]             m;
	} geom_t;

	typedef struct packed {
		logic [SIXV_W-1:0]         six_volume;
		logic                      over_bound;
		logic [2:0][SITE_W-1:0]    site;
		logic                      used_cc;
	} res_t;

endpackage

FILE: rtl/tet_circumcenter_volume_top.sv
// Top level of the tetrahedron six-volume and refinement-site block: register
// port, back-end tests, quotient lanes and output buffering.
// Depends on tcv_pkg, tcv_geom, tcv_mul and tcv_div.

// One tetrahedron is taken per clock cycle while the output buffer has room;
// the quotient lanes form the deepest part of the pipeline and resolve one
// bit of each site offset per stage (33 stages plus an overflow check);
// the volume, sliver and radius tests run alongside in
// 32x32 partial-product multipliers. A two-entry output buffer lets the
// block keep accepting while a result waits; s_tready drops only once both
// entries are full. Registers max_six_volume (address 0) and radius_limit
// (address 8) must be written while no tetrahedron is in flight.
module tet_circumcenter_volume_top import tcv_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	// a_x a_y a_z b_x b_y b_z c_x c_y c_z d_x d_y d_z, 16 bits each
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [IN_W-1:0]   s_tdata,
	// six_volume[50:0] over_bound[51] site_x[83:52] site_y[115:84]
	// site_z[147:116], zero pad
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [OUT_DW-1:0] m_tdata,
	// used_circumcenter[0]
	output logic              m_tuser,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	localparam int FLAG_DEP = DIV_LAT - 2 * MUL_LAT;
	localparam int FW       = QW + 2;

	logic [SIXV_W-1:0] max_vol_q;
	logic [RAD_W-1:0]  rad_q;
	logic [R2W-1:0]    r2_q;

	logic                               en;
	logic [NUM_CRD-1:0][COORD_BITS-1:0] crd;
	logic                               g_valid;
	geom_t                              geo;

	logic [V2W-1:0]       v2;
	logic [M2W-1:0]       m2;
	logic [N2W-1:0]       n2 [3];
	logic [V2W+SLIV_KW-1:0] sliv_p;
	logic [M3W-1:0]       m3;
	logic [V2W+R2W-1:0]   vr;
	logic [NW-1:0]        m_d_q [2];
	logic [NNW-1:0]       nn_a_q;
	logic [NNW-1:0]       nn_b_q;

	logic [1:0]  flag_q [FLAG_DEP];
	side_t       side_q [DIV_LAT];
	logic        sv_q   [DIV_LAT];

	logic [QW-1:0] dq   [3];
	logic          dovf [3];

	logic signed [FW-1:0] s_c [3];
	logic [2:0]           ok_c;
	logic                 use_c;
	res_t                 fin_c;

	logic fin_v_s;
	res_t fin_s;
	logic out_v_q;
	res_t out_q;
	logic skid_v_q;
	res_t skid_q;

	// Register port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_vol_q <= '0;
			rad_q     <= RAD_RESET;
			r2_q      <= R2W'(RAD_RESET) * R2W'(RAD_RESET);
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[3]))
					REG_MAX_VOL: max_vol_q <= pwdata[SIXV_W-1:0];
					REG_RAD_LIM: rad_q     <= pwdata[RAD_W-1:0];
					default: ;
				endcase
			end
			r2_q <= R2W'(rad_q) * R2W'(rad_q);
		end
	end

	always_comb begin
		case (reg_idx_t'(paddr[3]))
			REG_MAX_VOL: prdata = APB_DW'(max_vol_q);
			REG_RAD_LIM: prdata = APB_DW'(rad_q);
			default:     prdata = '0;
		endcase
	end

	assign pready = 1'b1;

	// Advance the whole pipeline while the output buffer has room
	assign en       = !skid_v_q;
	assign s_tready = en;
	assign crd      = s_tdata;

	tcv_geom u_geom (
		.clk            (clk),
		.arst_n         (arst_n),
		.en             (en),
		.in_valid       (s_tvalid),
		.crd            (crd),
		.max_six_volume (max_vol_q),
		.out_valid      (g_valid),
		.geo            (geo)
	);

	// Squares: V^2, M^2, N_k^2
	tcv_mul #(.AW(AVW), .BW(AVW)) u_mul_v2 (
		.clk(clk), .en(en), .a(geo.absv), .b(geo.absv), .p(v2));
	tcv_mul #(.AW(NW), .BW(NW)) u_mul_m2 (
		.clk(clk), .en(en), .a(geo.m), .b(geo.m), .p(m2));

	for (genvar k = 0; k < 3; k++) begin : g_lane
		tcv_mul #(.AW(ANW), .BW(ANW)) u_mul_n2 (
			.clk(clk), .en(en), .a(geo.absn[k]), .b(geo.absn[k]), .p(n2[k]));

		tcv_div u_div (
			.clk(clk), .en(en), .num(geo.num[k]), .den(geo.den),
			.q(dq[k]), .ovf(dovf[k]));
	end

	// Second products: 5^24 V^2, M^3, V^2 R^2
	tcv_mul #(.AW(V2W), .BW(SLIV_KW)) u_mul_sliv (
		.clk(clk), .en(en), .a(v2), .b(SLIV_K), .p(sliv_p));
	tcv_mul #(.AW(M2W), .BW(NW)) u_mul_m3 (
		.clk(clk), .en(en), .a(m2), .b(m_d_q[1]), .p(m3));
	tcv_mul #(.AW(V2W), .BW(R2W)) u_mul_vr (
		.clk(clk), .en(en), .a(v2), .b(r2_q), .p(vr));

	// Align M and |N|^2 with the second products, then test
	always_ff @(posedge clk) begin
		if (en) begin
			m_d_q[0] <= geo.m;
			m_d_q[1] <= m_d_q[0];
			nn_a_q   <= NNW'(n2[0]) + NNW'(n2[1]) + NNW'(n2[2]);
			nn_b_q   <= nn_a_q;
			flag_q[0][0] <= {sliv_p, SLIV_SH'(0)} >= (V2W+SLIV_KW+SLIV_SH)'(m3);
			flag_q[0][1] <= (V2W+R2W+2)'(nn_b_q) < {vr, 2'b00};
			for (int i = 1; i < FLAG_DEP; i++)
				flag_q[i] <= flag_q[i-1];
			side_q[0] <= geo.side;
			for (int i = 1; i < DIV_LAT; i++)
				side_q[i] <= side_q[i-1];
		end
	end

	// Valid bits alongside the quotient lanes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIV_LAT; i++)
				sv_q[i] <= 1'b0;
		end else if (en) begin
			sv_q[0] <= g_valid;
			for (int i = 1; i < DIV_LAT; i++)
				sv_q[i] <= sv_q[i-1];
		end
	end

	// Pick circumcenter or centroid
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			if (side_q[DIV_LAT-1].neg[k])
				s_c[k] = FW'($signed(side_q[DIV_LAT-1].a_fix[k])) - $signed(FW'(dq[k]));
			else
				s_c[k] = FW'($signed(side_q[DIV_LAT-1].a_fix[k])) + $signed(FW'(dq[k]));
			ok_c[k] = !dovf[k] && !dq[k][QW-1]
				&& ((&s_c[k][FW-1:SITE_W-1]) || !(|s_c[k][FW-1:SITE_W-1]));
		end
		use_c = side_q[DIV_LAT-1].vnz && flag_q[FLAG_DEP-1][0]
			&& flag_q[FLAG_DEP-1][1] && (&ok_c);
		fin_c.six_volume = side_q[DIV_LAT-1].six_volume;
		fin_c.over_bound = side_q[DIV_LAT-1].over_bound;
		fin_c.used_cc    = use_c;
		for (int k = 0; k < 3; k++)
			fin_c.site[k] = use_c ? SITE_W'(s_c[k]) : side_q[DIV_LAT-1].cent[k];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_v_s <= 1'b0;
		end else if (en) begin
			fin_v_s <= sv_q[DIV_LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fin_s <= fin_c;
		end
	end

	// Output register with one skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || m_tready) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= fin_v_s;
			end
		end else if (en && fin_v_s) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || m_tready) begin
			out_q <= skid_v_q ? skid_q : fin_s;
		end else if (en && fin_v_s) begin
			skid_q <= fin_s;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {(OUT_DW-SIXV_W-1-3*SITE_W)'(0), out_q.site[2], out_q.site[1],
		out_q.site[0], out_q.over_bound, out_q.six_volume};
	assign m_tuser  = out_q.used_cc;

	// The skid entry fills only behind a held output
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid entry valid with empty output register");

	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_v_q) |-> $past(out_v_q && !m_tready))
		else $error("skid entry filled while output was free");

	// A circumcenter site needs a nonzero volume
	a_cc_nonflat: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && out_q.used_cc) |-> (out_q.six_volume != '0))
		else $error("circumcenter reported for a flat tetrahedron");

endmodule

FILE: rtl/tcv_mul.sv
// Two-stage unsigned multiplier built from 32x32 partial products.
// Depends on tcv_pkg.
module tcv_mul import tcv_pkg::*; #(
	parameter int AW = 32,
	parameter int BW = 32
) (
	input  logic            clk,
	input  logic            en,
	input  logic [AW-1:0]   a,
	input  logic [BW-1:0]   b,
	output logic [AW+BW-1:0] p
);

	localparam int C  = MUL_CHUNK;
	localparam int NA = (AW + C - 1) / C;
	localparam int NB = (BW + C - 1) / C;
	localparam int SW = (NA + NB) * C;

	logic [NA*C-1:0] ax;
	logic [NB*C-1:0] bx;
	logic [2*C-1:0]  pp_s1 [NA*NB];
	logic [SW-1:0]   acc;

	assign ax = (NA*C)'(a);
	assign bx = (NB*C)'(b);

	// Stage 1: register the partial products
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NA; i++)
				for (int j = 0; j < NB; j++)
					pp_s1[i*NB+j] <= (2*C)'(ax[i*C +: C]) * (2*C)'(bx[j*C +: C]);
		end
	end

	// Stage 2: align and sum
	always_comb begin
		acc = '0;
		for (int i = 0; i < NA; i++)
			for (int j = 0; j < NB; j++)
				acc = acc + (SW'(pp_s1[i*NB+j]) << ((i + j) * C));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p <= (AW+BW)'(acc);
		end
	end

endmodule

FILE: rtl/tcv_div.sv
// Pipelined restoring divider, one quotient bit per stage, with an
// up-front overflow check. Depends on tcv_pkg.
module tcv_div import tcv_pkg::*; (
	input  logic            clk,
	input  logic            en,
	input  logic [NUMW-1:0] num,
	input  logic [DENW-1:0] den,
	output logic [QW-1:0]   q,
	output logic            ovf
);

	localparam int HIW = NUMW - QW;

	logic [DENW-1:0] rem_s [QW+1];
	logic [DENW-1:0] den_s [QW+1];
	logic [QW-1:0]   low_s [QW+1];
	logic [QW-1:0]   q_s   [QW+1];
	logic            ovf_s [QW+1];

	// Stage 0: quotient too wide when the high part already reaches den
	always_ff @(posedge clk) begin
		if (en) begin
			ovf_s[0] <= (HIW+DENW)'(num[NUMW-1:QW]) >= (HIW+DENW)'(den);
			rem_s[0] <= DENW'(num[NUMW-1:QW]);
			low_s[0] <= num[QW-1:0];
			den_s[0] <= den;
			q_s[0]   <= '0;
		end
	end

	// One bit per stage
	for (genvar i = 1; i <= QW; i++) begin : g_step
		logic [DENW:0] trial;
		logic          ge;

		assign trial = {rem_s[i-1], low_s[i-1][QW-1]};
		assign ge    = trial >= {1'b0, den_s[i-1]};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i] <= ge ? DENW'(trial - {1'b0, den_s[i-1]}) : DENW'(trial);
				low_s[i] <= low_s[i-1] << 1;
				den_s[i] <= den_s[i-1];
				q_s[i]   <= {q_s[i-1][QW-2:0], ge};
				ovf_s[i] <= ovf_s[i-1];
			end
		end
	end

	assign q   = q_s[QW];
	assign ovf = ovf_s[QW];

endmodule

FILE: rtl/tcv_geom.sv
// Front end: edge vectors, cross products, six-volume, circumcenter
// numerators, centroid and divider operands over six stages. Depends on tcv_pkg.
module tcv_geom import tcv_pkg::*; (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 en,
	input  logic                                 in_valid,
	input  logic [NUM_CRD-1:0][COORD_BITS-1:0]   crd,
	input  logic [SIXV_W-1:0]                    max_six_volume,
	output logic                                 out_valid,
	output geom_t                                geo
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	logic signed [COORD_BITS-1:0] a_s1 [3];
	logic signed [DW-1:0]         d_s1 [3][3];
	logic signed [SUMW-1:0]       sum_s1 [3];

	logic signed [2*DW-1:0]       xp_s2 [3][3][2];
	logic signed [2*DW-1:0]       sq_s2 [3][3];
	logic signed [DW-1:0]         b_s2 [3];
	logic signed [COORD_BITS-1:0] a_s2 [3];
	logic [SITE_W-1:0]            cent_s2 [3];

	logic signed [XW-1:0]         t_s3 [3][3];
	logic [NW-1:0]                n_s3 [3];
	logic signed [DW-1:0]         b_s3 [3];
	logic signed [COORD_BITS-1:0] a_s3 [3];
	logic [SITE_W-1:0]            cent_s3 [3];

	logic signed [VW-1:0]         vp_s4 [3];
	logic signed [NKW-1:0]        np_s4 [3][3];
	logic [NW-1:0]                m_s4;
	logic signed [COORD_BITS-1:0] a_s4 [3];
	logic [SITE_W-1:0]            cent_s4 [3];

	logic signed [VW-1:0]         v_val_s5;
	logic signed [NKW-1:0]        nk_s5 [3];
	logic [NW-1:0]                m_s5;
	logic signed [COORD_BITS-1:0] a_s5 [3];
	logic [SITE_W-1:0]            cent_s5 [3];

	geom_t                        geo_s6;

	logic signed [CENW-1:0] cn_c [3];
	logic [CENW-1:0]        mag_c [3];
	logic [CENW:0]          rnd_c [3];
	logic [SITE_W-1:0]      qc_c [3];
	logic [NW-1:0]          m_c;
	logic [AVW-1:0]         absv_c;
	logic [ANW-1:0]         absn_c [3];

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6} <= '0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// Stage 1: edge vectors from a and coordinate sums
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				a_s1[k] <= $signed(crd[k]);
				for (int v = 0; v < 3; v++)
					d_s1[v][k] <= DW'($signed(crd[3*(v+1)+k])) - DW'($signed(crd[k]));
				sum_s1[k] <= SUMW'($signed(crd[k])) + SUMW'($signed(crd[3+k]))
					+ SUMW'($signed(crd[6+k])) + SUMW'($signed(crd[9+k]));
			end
		end
	end

	// Centroid, rounded half away from zero
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			cn_c[k]  = CENW'(sum_s1[k]) <<< FRAC_BITS;
			mag_c[k] = cn_c[k][CENW-1] ? CENW'(-cn_c[k]) : CENW'(cn_c[k]);
			rnd_c[k] = {1'b0, mag_c[k]} + (CENW+1)'(2);
			qc_c[k]  = SITE_W'(rnd_c[k] >> 2);
		end
	end

	// Stage 2: cross-product and square terms
	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++) begin
				for (int k = 0; k < 3; k++) begin
					xp_s2[j][k][0] <= d_s1[(j+1)%3][(k+1)%3] * d_s1[(j+2)%3][(k+2)%3];
					xp_s2[j][k][1] <= d_s1[(j+1)%3][(k+2)%3] * d_s1[(j+2)%3][(k+1)%3];
					sq_s2[j][k]    <= d_s1[j][k] * d_s1[j][k];
				end
			end
			for (int k = 0; k < 3; k++) begin
				b_s2[k]    <= d_s1[0][k];
				a_s2[k]    <= a_s1[k];
				cent_s2[k] <= cn_c[k][CENW-1] ? -qc_c[k] : qc_c[k];
			end
		end
	end

	// Stage 3: cross products CxD, DxB, BxC and squared lengths
	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++) begin
				for (int k = 0; k < 3; k++)
					t_s3[j][k] <= XW'(xp_s2[j][k][0] - xp_s2[j][k][1]);
				n_s3[j] <= NW'(sq_s2[j][0] + sq_s2[j][1] + sq_s2[j][2]);
			end
			for (int k = 0; k < 3; k++) begin
				b_s3[k]    <= b_s2[k];
				a_s3[k]    <= a_s2[k];
				cent_s3[k] <= cent_s2[k];
			end
		end
	end

	// Longest squared edge from a
	always_comb begin
		m_c = n_s3[0];
		if (n_s3[1] > m_c) m_c = n_s3[1];
		if (n_s3[2] > m_c) m_c = n_s3[2];
	end

	// Stage 4: volume and numerator terms
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				vp_s4[k] <= VW'(b_s3[k]) * VW'(t_s3[0][k]);
				for (int j = 0; j < 3; j++)
					np_s4[j][k] <= NKW'($signed({1'b0, n_s3[j]})) * NKW'(t_s3[j][k]);
				a_s4[k]    <= a_s3[k];
				cent_s4[k] <= cent_s3[k];
			end
			m_s4 <= m_c;
		end
	end

	// Stage 5: sums
	always_ff @(posedge clk) begin
		if (en) begin
			v_val_s5 <= vp_s4[0] + vp_s4[1] + vp_s4[2];
			for (int k = 0; k < 3; k++) begin
				nk_s5[k]   <= np_s4[0][k] + np_s4[1][k] + np_s4[2][k];
				a_s5[k]    <= a_s4[k];
				cent_s5[k] <= cent_s4[k];
			end
			m_s5 <= m_s4;
		end
	end

	// Magnitudes
	always_comb begin
		absv_c = v_val_s5[VW-1] ? AVW'(-v_val_s5) : AVW'(v_val_s5);
		for (int k = 0; k < 3; k++)
			absn_c[k] = nk_s5[k][NKW-1] ? ANW'(-nk_s5[k]) : ANW'(nk_s5[k]);
	end

	// Stage 6: outputs, bound check and divider operands
	always_ff @(posedge clk) begin
		if (en) begin
			geo_s6.side.six_volume <= SIXV_W'(absv_c);
			geo_s6.side.over_bound <= (max_six_volume != '0) && (SIXV_W'(absv_c) > max_six_volume);
			geo_s6.side.vnz        <= v_val_s5 != '0;
			for (int k = 0; k < 3; k++) begin
				geo_s6.side.neg[k]   <= nk_s5[k][NKW-1] ^ v_val_s5[VW-1];
				geo_s6.side.a_fix[k] <= AFW'(AFW'(a_s5[k]) <<< FRAC_BITS);
				geo_s6.side.cent[k]  <= cent_s5[k];
				geo_s6.num[k]        <= (NUMW'(absn_c[k]) << FRAC_BITS) + NUMW'(absv_c);
				geo_s6.absn[k]       <= absn_c[k];
			end
			geo_s6.den  <= {absv_c, 1'b0};
			geo_s6.absv <= absv_c;
			geo_s6.m    <= m_s5;
		end
	end

	assign out_valid = v_s6;
	assign geo       = geo_s6;

endmodule
